// File: design/tait_eos_boundary_pressure_top_macros.svh
// Assertion macros used by the checker file.
`ifndef TAIT_EOS_BOUNDARY_PRESSURE_TOP_MACROS_SVH
`define TAIT_EOS_BOUNDARY_PRESSURE_TOP_MACROS_SVH

// Generic clocked check, disabled while reset is high.
`define TEP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A signal holds while its channel is stalled.
`define TEP_HOLD(lbl, vld, rdy, sig) \
  `TEP_CHECK(lbl, (vld && !rdy) |=> $stable(sig), "stalled word changed")

`endif

// File: design/tep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_pkg
// Shared constants and request types for the Tait / wall pressure block.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 64 + FRAC_BITS;
  localparam int DVSR_W    = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int RATIO_W   = 32 + FRAC_BITS;

  localparam logic [MUL_W-1:0] ONE = MUL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

endpackage

// File: design/tait_eos_boundary_pressure_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tait_eos_boundary_pressure_top
// Tait equation of state for fluid words and extrapolated wall pressure
// for boundary neighbor words, on one shared multiplier and one divider.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  item     item_valid / item_ready    opcode .. last_neighbor
//  result   result_valid / result_ready pressure_out .. is_boundary
//  cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Steps: a fluid word runs a serial divide for rho/rho0, then gamma+1
//   multiplies on the 32x32 partial-product multiplier. A boundary neighbor
//   takes four multiplies; the last one adds the final divide.
// Reset clears the sums, the control state and loads the default registers.
// item_ready is high only while the sequencer is idle. A finished result
//   waits in the output register; the next word is accepted meanwhile and
//   holds in its emit step only if the previous result is still not taken.
// ----------------------------------------------------------------------------
module tait_eos_boundary_pressure_top import tep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        opcode,
  input  logic [31:0] density,
  input  logic [47:0] neighbor_pressure,
  input  logic [31:0] kernel_weight,
  input  logic [31:0] height_diff,
  input  logic        neighbor_is_fluid,
  input  logic        last_neighbor,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [47:0] pressure_out,
  output logic [31:0] sound_speed_out,
  output logic [31:0] density_out,
  output logic        is_boundary,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // register indexes
  localparam logic [2:0] REG_STIFF = 3'd0;
  localparam logic [2:0] REG_SOUND = 3'd1;
  localparam logic [2:0] REG_RHO0  = 3'd2;
  localparam logic [2:0] REG_EXP   = 3'd3;
  localparam logic [2:0] REG_GRAV  = 3'd4;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MW     = 5'd1;   // wait on multiplier
  localparam logic [4:0] S_DW     = 5'd2;   // wait on divider
  localparam logic [4:0] S_RDIV   = 5'd3;
  localparam logic [4:0] S_RATIO  = 5'd4;
  localparam logic [4:0] S_POW    = 5'd5;
  localparam logic [4:0] S_POWUPD = 5'd6;
  localparam logic [4:0] S_PRES   = 5'd7;
  localparam logic [4:0] S_FOUT   = 5'd8;
  localparam logic [4:0] S_BP     = 5'd9;
  localparam logic [4:0] S_BP2    = 5'd10;
  localparam logic [4:0] S_BH2    = 5'd11;
  localparam logic [4:0] S_BH3    = 5'd12;
  localparam logic [4:0] S_BACC   = 5'd13;
  localparam logic [4:0] S_BLAST  = 5'd14;
  localparam logic [4:0] S_BDIV   = 5'd15;
  localparam logic [4:0] S_BQ     = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  localparam logic [63:0]    S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0]    S64_MIN = {1'b1, 63'd0};
  localparam logic [63:0]    N_MAX   = 64'h0000_8000_0000_0000;
  localparam logic [63:0]    P_MAX   = 64'h0000_7FFF_FFFF_FFFF;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] signed_mag(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    m = mag[63] ? S64_MAX : mag;
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [47:0] pack48(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (mag > N_MAX) ? N_MAX : mag;
      m = 64'd0 - m;
    end else begin
      m = (mag > P_MAX) ? P_MAX : mag;
    end
    return m[47:0];
  endfunction

  // configuration registers
  logic [47:0] tait_stiffness;
  logic [31:0] sound_speed;
  logic [31:0] rest_density;
  logic [2:0]  tait_exponent;
  logic [31:0] gravity;

  // running sums
  logic [63:0] pressure_sum;
  logic [63:0] hydro_sum;
  logic [47:0] weight_sum;

  // sequencer and working registers
  logic [4:0]         state;
  logic [4:0]         after;
  logic [31:0]        den;
  logic [47:0]        np;
  logic [31:0]        w;
  logic [31:0]        dy;
  logic               last;
  logic [RATIO_W-1:0] ratio;
  logic [MUL_W-1:0]   pw;
  logic [2:0]         cnt;
  logic [MUL_W-1:0]   tmp;
  logic [DIV_W-1:0]   qreg;
  logic               neg;
  logic [63:0]        padd;
  logic [63:0]        num;
  logic [47:0]        res_p;
  logic [31:0]        res_d;
  logic               res_b;

  mul_req_t          mul_req;
  logic              mul_done;
  logic [MUL_W-1:0]  mul_res;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic [31:0] r0;
  logic [47:0] pmag;
  logic [31:0] gmag;
  logic [31:0] ymag;
  logic [63:0] nmag;
  logic [63:0] pdiff;
  logic [48:0] ws_sum;
  logic [63:0] q_cap;

  assign r0    = (rest_density == 32'd0) ? 32'd1 : rest_density;
  assign pmag  = np[47] ? (48'd0 - np) : np;
  assign gmag  = gravity[31] ? (32'd0 - gravity) : gravity;
  assign ymag  = dy[31] ? (32'd0 - dy) : dy;
  assign nmag  = num[63] ? (64'd0 - num) : num;
  assign pdiff = (pw >= ONE) ? (pw - ONE) : (ONE - pw);
  assign ws_sum = {1'b0, weight_sum} + {17'd0, w};
  assign q_cap = (qreg > DIV_W'(N_MAX)) ? N_MAX : qreg[63:0];

  // operand selection for the shared units
  always_comb begin
    mul_req = '0;
    case (state)
      S_POW: begin
        mul_req.start = cnt < tait_exponent;
        mul_req.a     = pw;
        mul_req.b     = MUL_W'(ratio);
      end
      S_PRES: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_W'(tait_stiffness);
        mul_req.b     = pdiff;
      end
      S_BP: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_W'(pmag);
        mul_req.b     = MUL_W'(w);
      end
      S_BP2: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_W'(den);
        mul_req.b     = MUL_W'(gmag);
      end
      S_BH2: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmp;
        mul_req.b     = MUL_W'(ymag);
      end
      S_BH3: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmp;
        mul_req.b     = MUL_W'(w);
      end
      default: mul_req = '0;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_RDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({den, {FRAC_BITS{1'b0}}});
        div_req.divisor  = DVSR_W'(r0);
      end
      S_BDIV: begin
        div_req.start    = weight_sum != 48'd0;
        div_req.dividend = {nmag, {FRAC_BITS{1'b0}}};
        div_req.divisor  = weight_sum;
      end
      default: div_req = '0;
    endcase
  end

  tep_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .res  (mul_res)
  );

  tep_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  assign item_ready = state == S_IDLE;
  assign cfg_ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tait_stiffness <= 48'd6553600000;
      sound_speed    <= 32'd6553600;
      rest_density   <= 32'd65536000;
      tait_exponent  <= 3'd7;
      gravity        <= 32'd642908;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STIFF: tait_stiffness <= cfg_data;
        REG_SOUND: sound_speed    <= cfg_data[31:0];
        REG_RHO0:  rest_density   <= cfg_data[31:0];
        REG_EXP:   tait_exponent  <= cfg_data[2:0];
        REG_GRAV:  gravity        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      after        <= S_IDLE;
      result_valid <= 1'b0;
      pressure_sum <= '0;
      hydro_sum    <= '0;
      weight_sum   <= '0;
    end else begin
      // the emit step reloads the output register on its own
      if (result_valid && result_ready && state != S_EMIT) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            den  <= density;
            np   <= neighbor_pressure;
            w    <= kernel_weight;
            dy   <= height_diff;
            last <= last_neighbor;
            if (!opcode)                state <= S_RDIV;
            else if (neighbor_is_fluid) state <= S_BP;
            else                        state <= S_BLAST;
          end
        end
        S_MW: begin
          if (mul_done) begin
            tmp   <= mul_res;
            state <= after;
          end
        end
        S_DW: begin
          if (div_done) begin
            qreg  <= div_q;
            state <= after;
          end
        end
        // fluid: ratio, power, pressure
        S_RDIV: begin
          after <= S_RATIO;
          state <= S_DW;
        end
        S_RATIO: begin
          ratio <= qreg[RATIO_W-1:0];
          pw    <= ONE;
          cnt   <= 3'd0;
          state <= S_POW;
        end
        S_POW: begin
          if (cnt < tait_exponent) begin
            after <= S_POWUPD;
            state <= S_MW;
          end else begin
            state <= S_PRES;
          end
        end
        S_POWUPD: begin
          pw    <= tmp;
          cnt   <= cnt + 3'd1;
          state <= S_POW;
        end
        S_PRES: begin
          neg   <= pw < ONE;
          after <= S_FOUT;
          state <= S_MW;
        end
        S_FOUT: begin
          res_p <= pack48(tmp, neg);
          res_d <= den;
          res_b <= 1'b0;
          state <= S_EMIT;
        end
        // boundary neighbor: p*W, then rho*g*dy*W
        S_BP: begin
          after <= S_BP2;
          state <= S_MW;
        end
        S_BP2: begin
          padd  <= signed_mag(tmp, np[47]);
          after <= S_BH2;
          state <= S_MW;
        end
        S_BH2: begin
          after <= S_BH3;
          state <= S_MW;
        end
        S_BH3: begin
          after <= S_BACC;
          state <= S_MW;
        end
        S_BACC: begin
          pressure_sum <= sat_add(pressure_sum, padd);
          hydro_sum    <= sat_add(hydro_sum, signed_mag(tmp, gravity[31] ^ dy[31]));
          weight_sum   <= ws_sum[48] ? '1 : ws_sum[47:0];
          state        <= S_BLAST;
        end
        S_BLAST: begin
          if (!last) begin
            state <= S_IDLE;
          end else begin
            num   <= sat_add(pressure_sum, hydro_sum);
            state <= S_BDIV;
          end
        end
        S_BDIV: begin
          neg <= num[63];
          if (weight_sum == 48'd0) begin
            res_p        <= '0;
            res_d        <= rest_density;
            res_b        <= 1'b1;
            pressure_sum <= '0;
            hydro_sum    <= '0;
            state        <= S_EMIT;
          end else begin
            after <= S_BQ;
            state <= S_DW;
          end
        end
        S_BQ: begin
          res_p        <= pack48(q_cap, neg);
          res_d        <= rest_density;
          res_b        <= 1'b1;
          pressure_sum <= '0;
          hydro_sum    <= '0;
          weight_sum   <= '0;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid    <= 1'b1;
            pressure_out    <= res_p;
            sound_speed_out <= sound_speed;
            density_out     <= res_d;
            is_boundary     <= res_b;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/tep_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_mul
// Saturating (a*b) >> FRAC_BITS on 64-bit magnitudes, one 32x32 partial
// product per cycle.
// ----------------------------------------------------------------------------
module tep_mul import tep_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mul_req_t         req,
  output logic             done,
  output logic [MUL_W-1:0] res
);

  logic              busy;
  logic [2:0]        step;
  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  b_r;
  logic [MUL_W-1:0]  pp;
  logic [MUL_W-1:0]  prod;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] pp_al;
  logic [31:0]       opa;
  logic [31:0]       opb;
  logic              sat;

  always_comb begin
    case (step)
      3'd0: begin
        opa = a_r[31:0];
        opb = b_r[31:0];
      end
      3'd1: begin
        opa = a_r[31:0];
        opb = b_r[63:32];
      end
      3'd2: begin
        opa = a_r[63:32];
        opb = b_r[31:0];
      end
      default: begin
        opa = a_r[63:32];
        opb = b_r[63:32];
      end
    endcase
  end

  assign prod = {32'd0, opa} * {32'd0, opb};

  // placement of the product taken in the previous step
  always_comb begin
    case (step)
      3'd1:    pp_al = {64'd0, pp};
      3'd2:    pp_al = {32'd0, pp, 32'd0};
      3'd3:    pp_al = {32'd0, pp, 32'd0};
      3'd4:    pp_al = {pp, 64'd0};
      default: pp_al = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= 3'd0;
      a_r  <= req.a;
      b_r  <= req.b;
      acc  <= '0;
    end else if (busy) begin
      if (step < 3'd4) pp <= prod;
      acc  <= acc + pp_al;
      step <= step + 3'd1;
      if (step == 3'd5) busy <= 1'b0;
    end
  end

  assign done = busy && (step == 3'd5);
  assign sat  = |acc[PROD_W-1:MUL_W+FRAC_BITS];
  assign res  = sat ? '1 : acc[MUL_W+FRAC_BITS-1:FRAC_BITS];

endmodule

// File: design/tep_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tep_div import tep_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     q;
  logic [DVSR_W-1:0]    rem;
  logic [DVSR_W-1:0]    d;
  logic [DVSR_W:0]      rem_t;
  logic [DVSR_W:0]      diff;
  logic                 ge;

  assign rem_t = {rem, q[DIV_W-1]};
  assign ge    = rem_t >= {1'b0, d};
  assign diff  = rem_t - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      q    <= req.dividend;
      d    <= req.divisor;
      rem  <= '0;
    end else if (busy) begin
      if (cnt == DIV_CNT_W'(DIV_W)) begin
        busy <= 1'b0;
      end else begin
        rem <= ge ? diff[DVSR_W-1:0] : rem_t[DVSR_W-1:0];
        q   <= {q[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign done = busy && (cnt == DIV_CNT_W'(DIV_W));
  assign quot = q;

endmodule

// File: design/tep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_checker
// Port-level checks on the Tait / wall pressure block.
// ----------------------------------------------------------------------------
`include "tait_eos_boundary_pressure_top_macros.svh"

module tep_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [47:0] pressure_out
);

  `TEP_CHECK(busy_after_accept, (item_valid && item_ready) |=> !item_ready, "ready after accept")
  `TEP_CHECK(result_from_busy, $rose(result_valid) |-> !$past(item_ready), "result while idle")
  `TEP_HOLD(result_hold, result_valid, result_ready, pressure_out)

endmodule

bind tait_eos_boundary_pressure_top tep_checker u_tep_checker (.*);
